// ===== design/mp2a_pkg.sv =====
// ----------------------------------------------------------------------------
// mp2a_pkg
// Shared types and constants for the 2-D max pooling block with argmax.
// ----------------------------------------------------------------------------
`default_nettype none

package mp2a_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int INDEX_W    = 22;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_ADDR_W = 3;

  localparam int DEF_MAX_CHANNELS = 64;
  localparam int DEF_MAX_HEIGHT   = 256;
  localparam int DEF_MAX_WIDTH    = 256;
  localparam int DEF_MAX_KERNEL   = 8;
  localparam int DEF_QUEUE_DEPTH  = 4;

  // job fields sized for the largest supported geometry
  localparam int JOB_COL_W  = 12;
  localparam int JOB_BANK_W = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_CHANNELS   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_WIN_HEIGHT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_WIN_WIDTH  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_ROW_STRIDE = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_COL_STRIDE = 3'd6;

  typedef struct packed {
    logic [6:0] channels;
    logic [8:0] height;
    logic [8:0] width;
    logic [3:0] kh;
    logic [3:0] kw;
    logic [3:0] rs;
    logic [3:0] cs;
  } cfg_t;

  // one completed window, as handed from front to back
  typedef struct packed {
    logic [INDEX_W-1:0]    idx;   // flat index of the bottom-right sample
    logic [JOB_COL_W-1:0]  col;   // its column
    logic [JOB_BANK_W-1:0] bank;  // its line store bank
    logic                  last;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_FLUSH,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

// ===== design/max_pool_2d_argmax.sv =====
// ----------------------------------------------------------------------------
// max_pool_2d_argmax
// 2-D max pooling with argmax over a raster stream of Q16.16 samples.
// ----------------------------------------------------------------------------
//   port group | dir | handshake           | payload
//   in_        | in  | in_valid/in_ready   | in_sample
//   out_       | out | out_valid/out_ready | out_max_value, out_max_index,
//              |     |                     | out_last_window
//   cfg_       | in  | cfg_we              | cfg_index, cfg_data
//
// A sample is taken when in_valid and in_ready are both high. The back end
// evaluates a completed window one line store column per cycle across all banks.
// The first sample of a row waits until queued windows are evaluated.
// Reset is synchronous; no clearing pass. A stalled output holds the result.
`default_nettype none

module max_pool_2d_argmax import mp2a_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_KERNEL   = DEF_MAX_KERNEL,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int BW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [SAMPLE_W-1:0]   in_sample,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [SAMPLE_W-1:0]        out_max_value,
  output logic [INDEX_W-1:0]         out_max_index,
  output logic                       out_last_window
);

  cfg_t                cfg;
  logic                wr_en, push, q_full, q_valid, q_pop, back_busy;
  logic [BW-1:0]       wr_bank;
  logic [CW-1:0]       wr_addr, rd_addr;
  logic [SAMPLE_W-1:0] wr_data;
  logic [SAMPLE_W-1:0] rd_data [MAX_KERNEL];
  job_t                push_job, q_job;

  mp2a_front #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_KERNEL  (MAX_KERNEL)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .q_full    (q_full),
    .drain_busy(q_valid || back_busy),
    .cfg       (cfg),
    .wr_en     (wr_en),
    .wr_bank   (wr_bank),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .push_job  (push_job)
  );

  mp2a_queue #(
    .DEPTH(DEF_QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (q_job)
  );

  for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
    mp2a_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(MAX_WIDTH)
    ) u_ram (
      .clk  (clk),
      .we   (wr_en && (32'(wr_bank) == b)),
      .waddr(wr_addr),
      .wdata(wr_data),
      .raddr(rd_addr),
      .rdata(rd_data[b])
    );
  end

  mp2a_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_KERNEL(MAX_KERNEL)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_job          (q_job),
    .q_pop          (q_pop),
    .busy           (back_busy),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_max_value  (out_max_value),
    .out_max_index  (out_max_index),
    .out_last_window(out_last_window)
  );

endmodule

`default_nettype wire

// ===== design/mp2a_ram.sv =====
// ----------------------------------------------------------------------------
// mp2a_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2a_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== design/mp2a_front.sv =====
// ----------------------------------------------------------------------------
// mp2a_front
// Configuration registers, raster position tracking, line store writes and
// window detection. Each completed window is pushed to the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2a_front import mp2a_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_KERNEL   = DEF_MAX_KERNEL,
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int BW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1,
  localparam int PW  = $clog2(MAX_KERNEL + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [SAMPLE_W-1:0]   in_sample,
  input  wire logic                  q_full,
  input  wire logic                  drain_busy,
  output cfg_t                       cfg,
  output logic                       wr_en,
  output logic [BW-1:0]              wr_bank,
  output logic [CW-1:0]              wr_addr,
  output logic [SAMPLE_W-1:0]        wr_data,
  output logic                       push,
  output job_t                       push_job
);

  cfg_t              cfg_r;
  logic [CHW-1:0]    ch_r, ch_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [PW-1:0]     rph_r, rph_nxt;
  logic [PW-1:0]     cph_r, cph_nxt;
  logic [BW-1:0]     bank_r, bank_nxt;
  logic [INDEX_W-1:0] idx_r, idx_nxt;

  logic accept, row_ready, col_ready, row_hit, col_hit;
  logic col_end, row_end, ch_end, last;

  function automatic logic [8:0] clamp_reg(input logic [8:0] v, input int hi);
    if (v == 9'd0) return 9'd1;
    if (int'(v) > hi) return 9'(hi);
    return v;
  endfunction

  assign cfg = cfg_r;

  // a new row overwrites an old bank: let the back end finish reading first
  assign in_ready = !q_full && !((col_r == '0) && drain_busy);
  assign accept   = in_valid && in_ready;

  always_comb begin
    row_ready = (32'(row_r) + 1) >= 32'(cfg_r.kh);
    col_ready = (32'(col_r) + 1) >= 32'(cfg_r.kw);
    row_hit   = row_ready && (rph_r == '0);
    col_hit   = col_ready && (cph_r == '0);
    col_end   = (32'(col_r) + 1) >= 32'(cfg_r.width);
    row_end   = (32'(row_r) + 1) >= 32'(cfg_r.height);
    ch_end    = (32'(ch_r) + 1) >= 32'(cfg_r.channels);
    // final window: no further hit row or column fits in the plane
    last      = ch_end && ((32'(row_r) + 32'(cfg_r.rs)) >= 32'(cfg_r.height)) &&
                ((32'(col_r) + 32'(cfg_r.cs)) >= 32'(cfg_r.width));

    ch_nxt   = ch_r;
    row_nxt  = row_r;
    col_nxt  = col_r + 1'b1;
    rph_nxt  = rph_r;
    cph_nxt  = cph_r;
    bank_nxt = bank_r;
    idx_nxt  = idx_r + 1'b1;

    if (col_ready) begin
      cph_nxt = ((32'(cph_r) + 1) >= 32'(cfg_r.cs)) ? '0 : cph_r + 1'b1;
    end
    if (col_end) begin
      col_nxt = '0;
      cph_nxt = '0;
      if (row_ready) begin
        rph_nxt = ((32'(rph_r) + 1) >= 32'(cfg_r.rs)) ? '0 : rph_r + 1'b1;
      end
      row_nxt  = row_r + 1'b1;
      bank_nxt = ((32'(bank_r) + 1) >= MAX_KERNEL) ? '0 : bank_r + 1'b1;
      if (row_end) begin
        row_nxt  = '0;
        rph_nxt  = '0;
        bank_nxt = '0;
        ch_nxt   = ch_end ? '0 : ch_r + 1'b1;
        if (ch_end) begin
          idx_nxt = '0;
        end
      end
    end
  end

  assign wr_en   = accept;
  assign wr_bank = bank_r;
  assign wr_addr = col_r;
  assign wr_data = in_sample;

  assign push          = accept && row_hit && col_hit;
  assign push_job.idx  = idx_r;
  assign push_job.col  = JOB_COL_W'(col_r);
  assign push_job.bank = JOB_BANK_W'(bank_r);
  assign push_job.last = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channels <= 7'd1;
      cfg_r.height   <= 9'd8;
      cfg_r.width    <= 9'd8;
      cfg_r.kh       <= 4'd2;
      cfg_r.kw       <= 4'd2;
      cfg_r.rs       <= 4'd2;
      cfg_r.cs       <= 4'd2;
      ch_r   <= '0;
      row_r  <= '0;
      col_r  <= '0;
      rph_r  <= '0;
      cph_r  <= '0;
      bank_r <= '0;
      idx_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANNELS:
          cfg_r.channels <= 7'(clamp_reg({2'b0, cfg_data[6:0]}, MAX_CHANNELS));
        REG_HEIGHT:     cfg_r.height <= clamp_reg(cfg_data, MAX_HEIGHT);
        REG_WIDTH:      cfg_r.width  <= clamp_reg(cfg_data, MAX_WIDTH);
        REG_WIN_HEIGHT: cfg_r.kh <= 4'(clamp_reg({5'b0, cfg_data[3:0]}, MAX_KERNEL));
        REG_WIN_WIDTH:  cfg_r.kw <= 4'(clamp_reg({5'b0, cfg_data[3:0]}, MAX_KERNEL));
        REG_ROW_STRIDE: cfg_r.rs <= 4'(clamp_reg({5'b0, cfg_data[3:0]}, MAX_KERNEL));
        REG_COL_STRIDE: cfg_r.cs <= 4'(clamp_reg({5'b0, cfg_data[3:0]}, MAX_KERNEL));
        default: ;
      endcase
      if (cfg_index <= REG_COL_STRIDE) begin
        ch_r   <= '0;
        row_r  <= '0;
        col_r  <= '0;
        rph_r  <= '0;
        cph_r  <= '0;
        bank_r <= '0;
        idx_r  <= '0;
      end
    end else if (accept) begin
      ch_r   <= ch_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      rph_r  <= rph_nxt;
      cph_r  <= cph_nxt;
      bank_r <= bank_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/mp2a_queue.sv =====
// ----------------------------------------------------------------------------
// mp2a_queue
// Short FIFO of window jobs between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2a_queue import mp2a_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_job,
  output logic      full,
  input  wire logic pop,
  output logic      valid,
  output job_t      head
);

  job_t          slot_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [NW-1:0] cnt_r;

  assign full  = (32'(cnt_r) == DEPTH);
  assign valid = (cnt_r != '0);
  assign head  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= ((32'(wp_r) + 1) >= DEPTH) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= ((32'(rp_r) + 1) >= DEPTH) ? '0 : rp_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/mp2a_back.sv =====
// ----------------------------------------------------------------------------
// mp2a_back
// Window evaluation: reads one window column per cycle from all line store
// banks, reduces it with a compare tree, merges into the running maximum
// and places the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2a_back import mp2a_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_KERNEL = DEF_MAX_KERNEL,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int BW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1,
  localparam int LEAVES = 2 ** BW
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  cfg_t                     cfg,
  input  wire logic                q_valid,
  input  job_t                     q_job,
  output logic                     q_pop,
  output logic                     busy,
  output logic [CW-1:0]            rd_addr,
  input  wire logic [SAMPLE_W-1:0] rd_data [MAX_KERNEL],
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SAMPLE_W-1:0]      out_max_value,
  output logic [INDEX_W-1:0]       out_max_index,
  output logic                     out_last_window
);

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic [BW-1:0] j_r;
  logic        fl_r;
  logic        issue, load_out, last_col;

  // read stage tags
  logic          rv_r;
  logic [BW-1:0] rj_r;
  // column result
  logic                cv_r;
  logic [SAMPLE_W-1:0] cval_r;
  logic [BW-1:0]       cd_r, cj_r;
  // running best
  logic                have_r;
  logic [SAMPLE_W-1:0] bval_r;
  logic [BW-1:0]       bd_r, bj_r;

  logic                out_valid_r, out_last_r;
  logic [SAMPLE_W-1:0] out_value_r;
  logic [INDEX_W-1:0]  out_index_r;

  // compare tree; d is the row distance above the bottom row
  logic                nv   [2*LEAVES];
  logic [SAMPLE_W-1:0] nval [2*LEAVES];
  logic [BW-1:0]       nd   [2*LEAVES];

  logic              win;
  logic [BW+8:0]     row_off;
  logic [INDEX_W-1:0] fin_idx;

  assign last_col = (32'(j_r) + 1) >= 32'(cfg.kw);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:  if (q_valid) state_nxt = BK_RUN;
      BK_RUN:   if (last_col) state_nxt = BK_FLUSH;
      BK_FLUSH: if (fl_r) state_nxt = BK_DONE;
      BK_DONE:  if (!out_valid_r || out_ready) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    case (state_r)
      BK_IDLE: q_pop    = q_valid;
      BK_RUN:  issue    = 1'b1;
      BK_DONE: load_out = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign busy    = (state_r != BK_IDLE);
  assign rd_addr = CW'(32'(job_r.col) - 32'(cfg.kw) + 1 + 32'(j_r));

  always_comb begin
    int t;
    t = 0;
    for (int b = 0; b < LEAVES; b++) begin
      t = int'(job_r.bank) - b;
      if (t < 0) t = t + MAX_KERNEL;
      nv[LEAVES+b]   = (b < MAX_KERNEL) && (t < int'(cfg.kh));
      nval[LEAVES+b] = (b < MAX_KERNEL) ? rd_data[b % MAX_KERNEL] : '0;
      nd[LEAVES+b]   = BW'(t);
    end
    nv[0]   = 1'b0;
    nval[0] = '0;
    nd[0]   = '0;
    for (int n = LEAVES - 1; n >= 1; n--) begin
      // on a tie the upper row (larger distance) wins
      if (!nv[2*n+1] || (nv[2*n] && (($signed(nval[2*n]) > $signed(nval[2*n+1])) ||
          ((nval[2*n] == nval[2*n+1]) && (nd[2*n] > nd[2*n+1]))))) begin
        nv[n] = nv[2*n];   nval[n] = nval[2*n];   nd[n] = nd[2*n];
      end else begin
        nv[n] = nv[2*n+1]; nval[n] = nval[2*n+1]; nd[n] = nd[2*n+1];
      end
    end
  end

  // later columns win only on a larger value, or on equal value in an upper row
  assign win = !have_r || ($signed(cval_r) > $signed(bval_r)) ||
               ((cval_r == bval_r) && (cd_r > bd_r));

  assign row_off = (BW+9)'(bd_r) * (BW+9)'(cfg.width);
  assign fin_idx = job_r.idx - INDEX_W'(row_off) -
                   INDEX_W'(32'(cfg.kw) - 1 - 32'(bj_r));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
    rj_r   <= j_r;
    cval_r <= nval[1];
    cd_r   <= nd[1];
    cj_r   <= rj_r;
    if (cv_r && win) begin
      bval_r <= cval_r;
      bd_r   <= cd_r;
      bj_r   <= cj_r;
    end
    if (load_out) begin
      out_value_r <= bval_r;
      out_index_r <= fin_idx;
      out_last_r  <= job_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      j_r         <= '0;
      fl_r        <= 1'b0;
      rv_r        <= 1'b0;
      cv_r        <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= issue;
      cv_r    <= rv_r;
      if (q_pop) begin
        j_r    <= '0;
        have_r <= 1'b0;
      end else if (issue) begin
        j_r <= j_r + 1'b1;
      end
      if (cv_r) begin
        have_r <= 1'b1;
      end
      fl_r <= (state_r == BK_FLUSH) && !fl_r;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_max_value   = out_value_r;
  assign out_max_index   = out_index_r;
  assign out_last_window = out_last_r;

endmodule

`default_nettype wire

// ===== design/mp2a_checker.sv =====
// ----------------------------------------------------------------------------
// mp2a_checker
// Port-level checks on the pooling block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2a_checker import mp2a_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  cfg_we,
  input wire logic [CFG_ADDR_W-1:0] cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_data,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic [SAMPLE_W-1:0]   in_sample,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [SAMPLE_W-1:0]   out_max_value,
  input wire logic [INDEX_W-1:0]    out_max_index,
  input wire logic                  out_last_window
);

  // nothing comes out of reset as a pending word
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_max_value) && $stable(out_max_index) &&
      $stable(out_last_window))
    else $error("output word changed while stalled");

endmodule

bind max_pool_2d_argmax mp2a_checker u_mp2a_checker (.*);

`default_nettype wire

// ===== test/tb_max_pool_2d_argmax.sv =====
// ----------------------------------------------------------------------------
// tb_max_pool_2d_argmax
// Streams sample tensors through the pooling block under a range of window
// geometries, predicts each pooled word and its argmax index, and checks them.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_max_pool_2d_argmax;
  import mp2a_pkg::*;

  localparam int KMAX = 8;
  localparam int WMAX = 256;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [INDEX_W-1:0]  index;
    logic                last;
  } pooled_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SAMPLE_W-1:0] out_max_value;
  logic [INDEX_W-1:0] out_max_index;
  logic out_last_window;

  max_pool_2d_argmax i_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_sample,
    .out_valid, .out_ready, .out_max_value, .out_max_index, .out_last_window
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  int n_ch, n_h, n_w, k_h, k_w, s_r, s_c;
  logic signed [SAMPLE_W-1:0] rows [KMAX*WMAX];
  int ch, rw, cl, rph, cph, orow, ocol;
  pooled_t pooled_q[$];

  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 1'b0;
  int quiet = 0;
  int tensor_len;

  function automatic int clampv(int v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_pos();
    ch = 0; rw = 0; cl = 0; rph = 0; cph = 0; orow = 0; ocol = 0;
  endfunction

  function automatic void pool_sample(logic signed [SAMPLE_W-1:0] s);
    bit rr, cr, rh, ch_hit;
    int top, left, r, c, bidx;
    logic signed [SAMPLE_W-1:0] best, v;
    pooled_t p;
    rr = rw + 1 >= k_h;
    cr = cl + 1 >= k_w;
    rh = rr && rph == 0;
    ch_hit = cr && cph == 0;
    rows[(rw % KMAX) * WMAX + cl] = s;
    if (rh && ch_hit) begin
      top = rw + 1 - k_h;
      left = cl + 1 - k_w;
      best = rows[(top % KMAX) * WMAX + left];
      bidx = ch * n_h * n_w + top * n_w + left;
      for (int i = 0; i < k_h; i++)
        for (int j = 0; j < k_w; j++) begin
          r = top + i; c = left + j;
          v = rows[(r % KMAX) * WMAX + c];
          if (v > best) begin
            best = v;
            bidx = ch * n_h * n_w + r * n_w + c;
          end
        end
      p.value = best;
      p.index = bidx[INDEX_W-1:0];
      p.last = ch + 1 == n_ch && orow == (n_h - k_h) / s_r && ocol == (n_w - k_w) / s_c;
      pooled_q.push_back(p);
    end
    if (cr) begin
      if (ch_hit) ocol++;
      cph = (cph + 1 >= s_c) ? 0 : cph + 1;
    end
    cl++;
    if (cl >= n_w) begin
      cl = 0; cph = 0; ocol = 0;
      if (rr) begin
        if (rh) orow++;
        rph = (rph + 1 >= s_r) ? 0 : rph + 1;
      end
      rw++;
      if (rw >= n_h) begin
        rw = 0; rph = 0; orow = 0;
        ch++;
        if (ch >= n_ch) ch = 0;
      end
    end
  endfunction

  // write enable stays high across a run of writes; configure drops it
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    @(negedge clk);
    case (idx)
      REG_CHANNELS:   n_ch = clampv(val & 'h7f, 64);
      REG_HEIGHT:     n_h = clampv(val & 'h1ff, 256);
      REG_WIDTH:      n_w = clampv(val & 'h1ff, 256);
      REG_WIN_HEIGHT: k_h = clampv(val & 'hf, 8);
      REG_WIN_WIDTH:  k_w = clampv(val & 'hf, 8);
      REG_ROW_STRIDE: s_r = clampv(val & 'hf, 8);
      REG_COL_STRIDE: s_c = clampv(val & 'hf, 8);
      default: return;
    endcase
    restart_pos();
  endtask

  // waits for the block to drain before a register write
  task automatic drain();
    in_valid <= 1'b0;
    while (pooled_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic configure(int c, int h, int w, int kh, int kw, int rs, int cs);
    drain();
    write_reg(REG_CHANNELS, c);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_WIN_HEIGHT, kh);
    write_reg(REG_WIN_WIDTH, kw);
    write_reg(REG_ROW_STRIDE, rs);
    write_reg(REG_COL_STRIDE, cs);
    cfg_we <= 1'b0;
    tensor_len = n_ch * n_h * n_w;
  endtask

  // valid stays high into the next word unless the sender idles
  task automatic send_sample(logic [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    pool_sample(s);
    @(negedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(3) - 1;
      3: return 32'(int'($urandom_range(4)) - 2) << 16;
      default: return $urandom;
    endcase
  endfunction

  task automatic stream_tensors(int n);
    for (int i = 0; i < n; i++) send_sample(rand_sample());
  endtask

  task automatic test_directed();
    // reset geometry: 8x8, 2x2 windows, stride 2; extremes and ties
    tensor_len = 64;
    for (int i = 0; i < 24; i++)
      send_sample(i % 3 == 0 ? 32'h80000000 : (i % 5 == 0 ? 32'h7fffffff : 32'h0));
    configure(1, 3, 4, 2, 2, 1, 1);
    for (int i = 0; i < 12; i++) send_sample(32'h00010000); // all tied
    // out-of-range values: zero and above maximum, oversize window
    configure(0, 2, 2, 15, 0, 0, 15);
    stream_tensors(8);
    configure(2, 1, 1, 1, 1, 1, 1);
    stream_tensors(4);
  endtask

  task automatic test_random_geometry();
    int c, h, w;
    for (int g = 0; g < 12; g++) begin
      c = $urandom_range(1) + 1;
      h = $urandom_range(5) + 1;
      w = $urandom_range(5) + 1;
      configure(c, h, w, $urandom_range(4) + 1, $urandom_range(4) + 1,
                $urandom_range(3) + 1, $urandom_range(3) + 1);
      case (g % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      stream_tensors(tensor_len + $urandom_range(16));
    end
    idle_pct = 0; stall_pct = 0;
  endtask

  task automatic test_extreme_geometry();
    // largest window and channel settings, a 1x1 window at full plane width, and values above the maximum
    configure(64, 2, 256, 8, 8, 8, 8);
    stream_tensors(40);
    configure(1, 2, 256, 1, 1, 8, 8);
    stream_tensors(256);
    configure(127, 511, 511, 0, 0, 0, 0);
    stream_tensors(20);
  endtask

  task automatic test_back_pressure();
    configure(1, 4, 8, 1, 1, 1, 1);
    hold_off = 1'b1;
    fork
      stream_tensors(64);
      begin
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
    join
  endtask

  always @(negedge clk)
    out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    pooled_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pooled_q.size() == 0) begin
        $display("%0t: unexpected word value=%h index=%0d last=%b", $realtime,
                 out_max_value, out_max_index, out_last_window);
        errors++;
      end else begin
        want = pooled_q.pop_front();
        if (out_max_value !== want.value) begin
          $display("%0t: max_value expected %h actual %h", $realtime, want.value,
                   out_max_value);
          errors++;
        end
        if (out_max_index !== want.index) begin
          $display("%0t: max_index expected %0d actual %0d", $realtime, want.index,
                   out_max_index);
          errors++;
        end
        if (out_last_window !== want.last) begin
          $display("%0t: last_window expected %b actual %b", $realtime, want.last,
                   out_last_window);
          errors++;
        end
      end
    end
  end

  // counts cycles with no handshake on either side and no register write
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    n_ch = 1; n_h = 8; n_w = 8; k_h = 2; k_w = 2; s_r = 2; s_c = 2;
    restart_pos();
    foreach (rows[i]) rows[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_geometry();
    test_extreme_geometry();
    test_back_pressure();
    drain();
    if (errors == 0 && pooled_q.size() == 0) $display("TB_OK");
    else begin
      $display("%0t: %0d words still expected", $realtime, pooled_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
